### hdl/gcd_pkg.sv
`default_nettype none
package gcd_pkg;

  localparam int unsigned ANGLE_FRAC_BITS = 16;

  localparam int unsigned LAT_W  = 24;
  localparam int unsigned LON_W  = 25;
  localparam int unsigned DIST_W = 23;

  // 0.01745327 rad per degree in Q32
  localparam int unsigned    RPD_W           = 27;
  localparam logic [26:0]    RAD_PER_DEG_Q32 = 27'd74961224;

  // angles in Q30
  localparam logic [33:0] PI_Q30               = 34'd3373259426;
  localparam logic [33:0] TWO_PI_Q30           = 34'd6746518852;
  localparam logic [33:0] HALF_PI_Q30          = 34'd1686629713;
  localparam logic [33:0] QUARTER_PI_Q30       = 34'd843314857;
  localparam logic [33:0] THREE_QUARTER_PI_Q30 = 34'd2529944570;
  localparam logic signed [31:0] ONE_Q30       = 32'sd1073741824;

  // 6371.01 km in Q16
  localparam logic [28:0]        RADIUS_Q16 = 29'd417530511;
  localparam logic [DIST_W-1:0]  DIST_MAX   = 23'd5124096;

  localparam int unsigned TAYLOR_TERMS = 7;
  localparam int unsigned ACOS_STEPS   = 32;

  // round a Q60 product back to Q30, floor after adding one half
  function automatic logic signed [33:0] rnd_q30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd536870912;
    return 34'(t >>> 30);
  endfunction

endpackage
`default_nettype wire

### hdl/gcd_deg2rad.sv
`default_nettype none
module gcd_deg2rad #(
  parameter int unsigned DEG_W     = 24,
  parameter int unsigned FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS,
  parameter int unsigned RAD_W     = DEG_W + gcd_pkg::RPD_W - FRAC_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [DEG_W-1:0] deg_i,
  output logic                    valid_o,
  output logic signed [RAD_W-1:0] rad_o
);
  localparam int unsigned PROD_W = DEG_W + gcd_pkg::RPD_W;
  localparam int unsigned SH     = FRAC_BITS + 2;
  localparam logic [PROD_W:0] HALF_LSB = (PROD_W + 1)'(1) << (SH - 1);

  logic [DEG_W-1:0]  mag_d, mag_q;
  logic              neg1_q, neg2_q;
  logic              v1_q, v2_q, v3_q;
  logic [PROD_W-1:0] prod_q;
  logic [PROD_W:0]   sum_w;
  logic [RAD_W-1:0]  mag_r;
  logic signed [RAD_W-1:0] rad_d, rad_q;

  assign mag_d = deg_i[DEG_W-1] ? (~deg_i + 1'b1) : deg_i;
  assign sum_w = {1'b0, prod_q} + HALF_LSB;
  assign mag_r = RAD_W'(sum_w >> SH);
  assign rad_d = neg2_q ? -$signed(mag_r) : $signed(mag_r);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      neg1_q <= deg_i[DEG_W-1];
      prod_q <= PROD_W'(mag_q) * PROD_W'(gcd_pkg::RAD_PER_DEG_Q32);
      neg2_q <= neg1_q;
      rad_q  <= rad_d;
    end
  end

  assign valid_o = v3_q;
  assign rad_o   = rad_q;

endmodule
`default_nettype wire

### hdl/gcd_sincos.sv
`default_nettype none
module gcd_sincos #(
  parameter int unsigned ANG_W = 34,
  parameter int unsigned TAG_W = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [ANG_W-1:0] ang_i,
  input  logic [TAG_W-1:0]        tag_i,
  output logic                    valid_o,
  output logic signed [31:0]      sin_o,
  output logic signed [31:0]      cos_o,
  output logic [TAG_W-1:0]        tag_o
);
  localparam int unsigned MW        = (ANG_W > 34) ? ANG_W : 34;
  localparam int unsigned RED_STEPS = (ANG_W > 33) ? ANG_W - 32 : 1;
  localparam int unsigned NT        = gcd_pkg::TAYLOR_TERMS;

  typedef enum logic [2:0] {
    QD_ZERO = 3'b000,
    QD_POS1 = 3'b001,
    QD_POS2 = 3'b010,
    QD_NEG1 = 3'b011,
    QD_NEG2 = 3'b100
  } quad_e;

  // stage 1: magnitude reduced modulo two pi
  logic [ANG_W-1:0] mag1;
  logic [MW-1:0]    red_d;
  logic [33:0]      m1_q;
  logic             neg1_q, v1_q;
  logic [TAG_W-1:0] tag1_q;

  assign mag1 = ang_i[ANG_W-1] ? (~ang_i + 1'b1) : ang_i;

  always_comb begin
    red_d = MW'(mag1);
    for (int k = int'(RED_STEPS) - 1; k >= 0; k--) begin
      if (red_d >= (MW'(gcd_pkg::TWO_PI_Q30) << k)) begin
        red_d = red_d - (MW'(gcd_pkg::TWO_PI_Q30) << k);
      end
    end
  end

  // stage 2: fold into [-pi, pi], pick the quadrant
  logic [33:0]        m2, fold;
  logic               neg2;
  quad_e              quad_d;
  logic signed [35:0] xm;
  logic signed [31:0] x_d, x_q;
  quad_e              q2_q;
  logic               v2_q;
  logic [TAG_W-1:0]   tag2_q;

  always_comb begin
    m2   = m1_q;
    neg2 = neg1_q;
    if (m2 > gcd_pkg::PI_Q30) begin
      m2   = gcd_pkg::TWO_PI_Q30 - m2;
      neg2 = !neg2;
    end
    if (m2 > gcd_pkg::THREE_QUARTER_PI_Q30) begin
      quad_d = neg2 ? QD_NEG2 : QD_POS2;
      fold   = gcd_pkg::HALF_PI_Q30 << 1;
    end else if (m2 > gcd_pkg::QUARTER_PI_Q30) begin
      quad_d = neg2 ? QD_NEG1 : QD_POS1;
      fold   = gcd_pkg::HALF_PI_Q30;
    end else begin
      quad_d = QD_ZERO;
      fold   = '0;
    end
    xm  = $signed({2'b00, m2}) - $signed({2'b00, fold});
    x_d = neg2 ? 32'(-xm) : 32'(xm);
  end

  // stage 3: x squared, series seeds
  logic signed [63:0] xx;
  logic signed [31:0] ts0_q, s0_q, tc0_q, c0_q, x20_q;
  quad_e              q0_q;
  logic               v0_q;
  logic [TAG_W-1:0]   tag0_q;

  assign xx = x_q * x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v0_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v0_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q   <= 34'(red_d);
      neg1_q <= ang_i[ANG_W-1];
      tag1_q <= tag_i;
      x_q    <= x_d;
      q2_q   <= quad_d;
      tag2_q <= tag1_q;
      x20_q  <= 32'(gcd_pkg::rnd_q30(xx));
      ts0_q  <= x_q;
      s0_q   <= x_q;
      tc0_q  <= gcd_pkg::ONE_Q30;
      c0_q   <= gcd_pkg::ONE_Q30;
      q0_q   <= q2_q;
      tag0_q <= tag2_q;
    end
  end

  logic signed [31:0] ts_w  [NT+1];
  logic signed [31:0] s_w   [NT+1];
  logic signed [31:0] tc_w  [NT+1];
  logic signed [31:0] c_w   [NT+1];
  logic signed [31:0] x2_w  [NT+1];
  quad_e              q_w   [NT+1];
  logic               v_w   [NT+1];
  logic [TAG_W-1:0]   tag_w [NT+1];

  assign ts_w[0]  = ts0_q;
  assign s_w[0]   = s0_q;
  assign tc_w[0]  = tc0_q;
  assign c_w[0]   = c0_q;
  assign x2_w[0]  = x20_q;
  assign q_w[0]   = q0_q;
  assign v_w[0]   = v0_q;
  assign tag_w[0] = tag0_q;

  // one series term per three stages: product, divide by reciprocal, accumulate
  for (genvar g = 1; g <= NT; g++) begin : g_term
    localparam int unsigned DS = (2 * g) * (2 * g + 1);
    localparam int unsigned DC = (2 * g - 1) * (2 * g);
    localparam int unsigned SS = 31 + $clog2(DS);
    localparam int unsigned SC = 31 + $clog2(DC);
    localparam logic [63:0] MS_W = ((64'd1 << SS) + 64'(DS) - 64'd1) / 64'(DS);
    localparam logic [63:0] MC_W = ((64'd1 << SC) + 64'(DC) - 64'd1) / 64'(DC);
    localparam logic [31:0] MS = MS_W[31:0];
    localparam logic [31:0] MC = MC_W[31:0];

    logic signed [63:0] pa_s_q, pa_c_q;
    logic signed [31:0] sa_q, ca_q, x2a_q;
    quad_e              qa_q;
    logic               va_q;
    logic [TAG_W-1:0]   taga_q;

    logic signed [33:0] rb_s, rb_c;
    logic [30:0]        mb_s, mb_c;
    logic [62:0]        nb_s_q, nb_c_q;
    logic               negb_s_q, negb_c_q;
    logic signed [31:0] sb_q, cb_q, x2b_q;
    quad_e              qb_q;
    logic               vb_q;
    logic [TAG_W-1:0]   tagb_q;

    logic [31:0]        qt_s, qt_c;
    logic signed [31:0] term_s, term_c;
    logic signed [31:0] tsc_q, sc_q, tcc_q, cc_q, x2c_q;
    quad_e              qc_q;
    logic               vc_q;
    logic [TAG_W-1:0]   tagc_q;

    assign rb_s = gcd_pkg::rnd_q30(pa_s_q);
    assign rb_c = gcd_pkg::rnd_q30(pa_c_q);
    assign mb_s = rb_s[33] ? 31'(-rb_s) : 31'(rb_s);
    assign mb_c = rb_c[33] ? 31'(-rb_c) : 31'(rb_c);

    assign qt_s   = 32'(nb_s_q >> SS);
    assign qt_c   = 32'(nb_c_q >> SC);
    // the next term carries the opposite sign of the rounded product
    assign term_s = negb_s_q ? $signed(qt_s) : -$signed(qt_s);
    assign term_c = negb_c_q ? $signed(qt_c) : -$signed(qt_c);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        va_q <= 1'b0;
        vb_q <= 1'b0;
        vc_q <= 1'b0;
      end else if (en_i) begin
        va_q <= v_w[g-1];
        vb_q <= va_q;
        vc_q <= vb_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_s_q   <= ts_w[g-1] * x2_w[g-1];
        pa_c_q   <= tc_w[g-1] * x2_w[g-1];
        sa_q     <= s_w[g-1];
        ca_q     <= c_w[g-1];
        x2a_q    <= x2_w[g-1];
        qa_q     <= q_w[g-1];
        taga_q   <= tag_w[g-1];

        nb_s_q   <= 63'(mb_s) * 63'(MS);
        nb_c_q   <= 63'(mb_c) * 63'(MC);
        negb_s_q <= rb_s[33];
        negb_c_q <= rb_c[33];
        sb_q     <= sa_q;
        cb_q     <= ca_q;
        x2b_q    <= x2a_q;
        qb_q     <= qa_q;
        tagb_q   <= taga_q;

        tsc_q    <= term_s;
        tcc_q    <= term_c;
        sc_q     <= sb_q + term_s;
        cc_q     <= cb_q + term_c;
        x2c_q    <= x2b_q;
        qc_q     <= qb_q;
        tagc_q   <= tagb_q;
      end
    end

    assign ts_w[g]  = tsc_q;
    assign s_w[g]   = sc_q;
    assign tc_w[g]  = tcc_q;
    assign c_w[g]   = cc_q;
    assign x2_w[g]  = x2c_q;
    assign q_w[g]   = qc_q;
    assign v_w[g]   = vc_q;
    assign tag_w[g] = tagc_q;
  end

  // quadrant mapping
  logic signed [31:0] sin_d, cos_d, sin_q, cos_q;
  logic               vo_q;
  logic [TAG_W-1:0]   tago_q;

  always_comb begin
    case (q_w[NT])
      QD_POS1: begin
        sin_d = c_w[NT];
        cos_d = -s_w[NT];
      end
      QD_POS2, QD_NEG2: begin
        sin_d = -s_w[NT];
        cos_d = -c_w[NT];
      end
      QD_NEG1: begin
        sin_d = -c_w[NT];
        cos_d = s_w[NT];
      end
      default: begin
        sin_d = s_w[NT];
        cos_d = c_w[NT];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_w[NT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q  <= sin_d;
      cos_q  <= cos_d;
      tago_q <= tag_w[NT];
    end
  end

  assign valid_o = vo_q;
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;
  assign tag_o   = tago_q;

endmodule
`default_nettype wire

### hdl/gcd_acos.sv
`default_nettype none
module gcd_acos (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] c_i,
  output logic               valid_o,
  output logic [31:0]        theta_o
);
  localparam int unsigned N = gcd_pkg::ACOS_STEPS;

  logic [31:0]        lo_w [N+1];
  logic [31:0]        hi_w [N+1];
  logic signed [31:0] c_w  [N+1];
  logic               v_w  [N+1];

  assign lo_w[0] = '0;
  assign hi_w[0] = 32'(gcd_pkg::PI_Q30);
  assign c_w[0]  = c_i;
  assign v_w[0]  = valid_i;

  // one bisection step: midpoint, cosine pipeline, narrow the bracket
  for (genvar i = 0; i < N; i++) begin : g_step
    logic [31:0]        mid_q, lom_q, him_q;
    logic signed [31:0] cm_q;
    logic               vm_q;
    logic [32:0]        lh_sum;

    logic               vs;
    logic signed [31:0] cos_s;
    logic [127:0]       tag_s;
    logic signed [31:0] cs_t;

    logic [31:0]        lou_q, hiu_q;
    logic signed [31:0] cu_q;
    logic               vu_q;

    assign lh_sum = {1'b0, lo_w[i]} + {1'b0, hi_w[i]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vm_q <= 1'b0;
        vu_q <= 1'b0;
      end else if (en_i) begin
        vm_q <= v_w[i];
        vu_q <= vs;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mid_q <= lh_sum[32:1];
        lom_q <= lo_w[i];
        him_q <= hi_w[i];
        cm_q  <= c_w[i];
      end
    end

    gcd_sincos #(
      .ANG_W (33),
      .TAG_W (128)
    ) u_cos (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (vm_q),
      .ang_i   ($signed({1'b0, mid_q})),
      .tag_i   ({cm_q, lom_q, him_q, mid_q}),
      .valid_o (vs),
      .sin_o   (),
      .cos_o   (cos_s),
      .tag_o   (tag_s)
    );

    assign cs_t = $signed(tag_s[127:96]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cu_q <= cs_t;
        if (cos_s > cs_t) begin
          lou_q <= tag_s[31:0];
          hiu_q <= tag_s[63:32];
        end else begin
          lou_q <= tag_s[95:64];
          hiu_q <= tag_s[31:0];
        end
      end
    end

    assign lo_w[i+1] = lou_q;
    assign hi_w[i+1] = hiu_q;
    assign c_w[i+1]  = cu_q;
    assign v_w[i+1]  = vu_q;
  end

  assign valid_o = v_w[N];
  assign theta_o = lo_w[N];

endmodule
`default_nettype wire

### hdl/great_circle_distance.sv
// Great-circle distance between two points by the spherical law of cosines. Angles
// come in as degrees with ANGLE_FRAC_BITS fractional bits, the result leaves in
// units of 1/256 km, saturating. The block is one long pipeline: an input register
// that also forms the longitude difference, degree to radian, series sin/cos, the
// cosine sum with its clamp, an arc cosine of 32 bisection steps, the radius scaling
// and the output register. A new pair can be taken in every cycle while in_ready_o
// is high. Behind the output register sits a single skid entry; while that entry
// holds a beat the whole pipeline pauses and in_ready_o is low.
`default_nettype none
module great_circle_distance #(
  parameter int unsigned ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [gcd_pkg::LAT_W-1:0]   first_latitude_i,
  input  logic signed [gcd_pkg::LON_W-1:0]   first_longitude_i,
  input  logic signed [gcd_pkg::LAT_W-1:0]   second_latitude_i,
  input  logic signed [gcd_pkg::LON_W-1:0]   second_longitude_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [gcd_pkg::DIST_W-1:0]         distance_km_o
);
  localparam int unsigned LAT_W  = gcd_pkg::LAT_W;
  localparam int unsigned DLON_W = gcd_pkg::LON_W + 1;
  localparam int unsigned DIST_W = gcd_pkg::DIST_W;
  localparam int unsigned LAT_RAD_W = LAT_W + gcd_pkg::RPD_W - ANGLE_FRAC_BITS;
  localparam int unsigned LON_RAD_W = DLON_W + gcd_pkg::RPD_W - ANGLE_FRAC_BITS;

  logic en;
  logic out_v_q, skid_v_q;
  logic [DIST_W-1:0] out_dist_q, skid_dist_q;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  // input register with longitude difference
  logic signed [LAT_W-1:0]  lat1_q, lat2_q;
  logic signed [DLON_W-1:0] dlon_q;
  logic                     v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lat1_q <= first_latitude_i;
      lat2_q <= second_latitude_i;
      dlon_q <= DLON_W'(first_longitude_i) - DLON_W'(second_longitude_i);
    end
  end

  logic                        vr;
  logic signed [LAT_RAD_W-1:0] rlat1, rlat2;
  logic signed [LON_RAD_W-1:0] rdlon;

  gcd_deg2rad #(.DEG_W(LAT_W), .FRAC_BITS(ANGLE_FRAC_BITS)) u_rad_lat1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v0_q), .deg_i(lat1_q),
    .valid_o(vr), .rad_o(rlat1)
  );
  gcd_deg2rad #(.DEG_W(LAT_W), .FRAC_BITS(ANGLE_FRAC_BITS)) u_rad_lat2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v0_q), .deg_i(lat2_q),
    .valid_o(), .rad_o(rlat2)
  );
  gcd_deg2rad #(.DEG_W(DLON_W), .FRAC_BITS(ANGLE_FRAC_BITS)) u_rad_dlon (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v0_q), .deg_i(dlon_q),
    .valid_o(), .rad_o(rdlon)
  );

  logic               vt;
  logic signed [31:0] s1, c1, s2, c2, cd;

  gcd_sincos #(.ANG_W(LAT_RAD_W), .TAG_W(1)) u_sc_lat1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vr), .ang_i(rlat1), .tag_i(1'b0),
    .valid_o(vt), .sin_o(s1), .cos_o(c1), .tag_o()
  );
  gcd_sincos #(.ANG_W(LAT_RAD_W), .TAG_W(1)) u_sc_lat2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vr), .ang_i(rlat2), .tag_i(1'b0),
    .valid_o(), .sin_o(s2), .cos_o(c2), .tag_o()
  );
  gcd_sincos #(.ANG_W(LON_RAD_W), .TAG_W(1)) u_sc_dlon (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vr), .ang_i(rdlon), .tag_i(1'b0),
    .valid_o(), .sin_o(), .cos_o(cd), .tag_o()
  );

  // cosine of the central angle
  logic signed [63:0] pss_q, pcc_q, p3_q;
  logic signed [31:0] cd1_q, rss_q, ca_q;
  logic signed [31:0] rcc;
  logic signed [34:0] sum_d;
  logic               v1_q, v2_q, v3_q;

  assign rcc   = 32'(gcd_pkg::rnd_q30(pcc_q));
  assign sum_d = 35'(rss_q) + 35'(gcd_pkg::rnd_q30(p3_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= vt;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pss_q <= s1 * s2;
      pcc_q <= c1 * c2;
      cd1_q <= cd;
      rss_q <= 32'(gcd_pkg::rnd_q30(pss_q));
      p3_q  <= rcc * cd1_q;
      if (sum_d > 35'(gcd_pkg::ONE_Q30)) begin
        ca_q <= gcd_pkg::ONE_Q30;
      end else if (sum_d < -35'(gcd_pkg::ONE_Q30)) begin
        ca_q <= -gcd_pkg::ONE_Q30;
      end else begin
        ca_q <= 32'(sum_d);
      end
    end
  end

  logic        va;
  logic [31:0] theta;

  gcd_acos u_acos (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3_q), .c_i(ca_q),
    .valid_o(va), .theta_o(theta)
  );

  // scale by the radius
  logic [60:0] prod_q;
  logic        vd_q;
  logic [61:0] dr;
  logic [23:0] dq;
  logic [DIST_W-1:0] dist_d;
  logic        arr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en) begin
      vd_q <= va;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= 61'(theta) * 61'(gcd_pkg::RADIUS_Q16);
    end
  end

  assign dr     = {1'b0, prod_q} + (62'd1 << 37);
  assign dq     = 24'(dr >> 38);
  assign dist_d = (dq > 24'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX : DIST_W'(dq);
  assign arr    = en && vd_q;

  // output register plus one skid entry
  logic out_free;
  assign out_free = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q  <= skid_v_q || arr;
      skid_v_q <= 1'b0;
    end else if (arr) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_dist_q <= skid_v_q ? skid_dist_q : dist_d;
    end else if (arr) begin
      skid_dist_q <= dist_d;
    end
  end

  assign out_valid_o   = out_v_q;
  assign distance_km_o = out_dist_q;

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry holds a beat while the output register is empty");

  a_dist_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_dist_q <= gcd_pkg::DIST_MAX))
    else $error("distance beyond saturation limit");

  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_ready_i))
    else $error("skid entry filled while the output could move");

endmodule
`default_nettype wire

### sim/gcd_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module gcd_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic signed [gcd_pkg::LAT_W-1:0]  first_latitude_i,
  input  logic signed [gcd_pkg::LON_W-1:0]  first_longitude_i,
  input  logic signed [gcd_pkg::LAT_W-1:0]  second_latitude_i,
  input  logic signed [gcd_pkg::LON_W-1:0]  second_longitude_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [gcd_pkg::DIST_W-1:0]        distance_km_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                checked_o
);

  localparam longint PI_L      = 64'd3373259426;
  localparam longint TWO_PI_L  = 64'd6746518852;
  localparam longint HALF_PI_L = 64'd1686629713;
  localparam longint QPI_L     = 64'd843314857;
  localparam longint TQPI_L    = 64'd2529944570;
  localparam longint ONE_L     = 64'd1073741824;

  logic [gcd_pkg::DIST_W-1:0] distance_queue[$];

  function automatic longint q30_mul(input longint a, input longint b);
    longint p;
    p = a * b + (ONE_L >>> 1);
    return p >>> 30;
  endfunction

  // scale magnitude, round, then restore the sign
  function automatic longint rad_from_deg(input longint deg);
    longint mag;
    longint r;
    mag = (deg < 0) ? -deg : deg;
    r = (mag * longint'(gcd_pkg::RAD_PER_DEG_Q32) +
         (64'sd1 <<< (gcd_pkg::ANGLE_FRAC_BITS + 1)))
        >>> (gcd_pkg::ANGLE_FRAC_BITS + 2);
    return (deg < 0) ? -r : r;
  endfunction

  task automatic sin_cos_q30(input longint a, output longint sn, output longint cs);
    longint r, q, x, x2, ts, tc, s, c;
    r = a % TWO_PI_L;
    q = 0;
    if (r > PI_L) r -= TWO_PI_L;
    else if (r < -PI_L) r += TWO_PI_L;
    if (r > TQPI_L) q = 2;
    else if (r > QPI_L) q = 1;
    else if (r < -TQPI_L) q = -2;
    else if (r < -QPI_L) q = -1;
    x = r - q * HALF_PI_L;
    x2 = q30_mul(x, x);
    ts = x;
    s = x;
    tc = ONE_L;
    c = ONE_L;
    for (int k = 1; k <= 7; k++) begin
      ts = -q30_mul(ts, x2) / longint'((2 * k) * (2 * k + 1));
      s += ts;
      tc = -q30_mul(tc, x2) / longint'((2 * k - 1) * (2 * k));
      c += tc;
    end
    case (q)
      1: begin sn = c; cs = -s; end
      2, -2: begin sn = -s; cs = -c; end
      -1: begin sn = -c; cs = s; end
      default: begin sn = s; cs = c; end
    endcase
  endtask

  task automatic central_angle(input longint c, output longint theta);
    longint lo, hi, mid, s, cm;
    lo = 0;
    hi = PI_L;
    for (int i = 0; i < 32; i++) begin
      mid = (lo + hi) / 2;
      sin_cos_q30(mid, s, cm);
      if (cm > c) lo = mid;
      else hi = mid;
    end
    theta = lo;
  endtask

  task automatic predict_distance(input longint lat1, input longint lon1,
                                  input longint lat2, input longint lon2,
                                  output logic [gcd_pkg::DIST_W-1:0] expected);
    longint s1, c1, s2, c2, sd, cd, sum, theta, d;
    sin_cos_q30(rad_from_deg(lat1), s1, c1);
    sin_cos_q30(rad_from_deg(lat2), s2, c2);
    sin_cos_q30(rad_from_deg(lon1 - lon2), sd, cd);
    sum = q30_mul(s1, s2) + q30_mul(q30_mul(c1, c2), cd);
    if (sum > ONE_L) sum = ONE_L;
    if (sum < -ONE_L) sum = -ONE_L;
    central_angle(sum, theta);
    d = (theta * longint'(gcd_pkg::RADIUS_Q16) + (64'sd1 <<< 37)) >>> 38;
    if (d > longint'(gcd_pkg::DIST_MAX)) d = longint'(gcd_pkg::DIST_MAX);
    expected = d[gcd_pkg::DIST_W-1:0];
  endtask

  assign pending_o = distance_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [gcd_pkg::DIST_W-1:0] want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      checked_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        predict_distance(first_latitude_i, first_longitude_i,
                         second_latitude_i, second_longitude_i, want);
        distance_queue.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        checked_o <= checked_o + 1;
        if (distance_queue.size() == 0) begin
          $error("distance_km: unexpected beat, actual %0d", distance_km_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = distance_queue.pop_front();
          if (distance_km_i !== want) begin
            $error("distance_km: expected %0d, actual %0d", want, distance_km_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

### sim/great_circle_distance_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module great_circle_distance_tb;

  localparam int LAT_W        = gcd_pkg::LAT_W;
  localparam int LON_W        = gcd_pkg::LON_W;
  localparam int DIST_W       = gcd_pkg::DIST_W;
  localparam int RANDOM_PAIRS = 1500;
  localparam int STALL_LIMIT  = 6000;
  localparam int LAT_MAX      = 5898240;
  localparam int LON_MAX      = 11796480;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [LAT_W-1:0] first_latitude_i;
  logic signed [LON_W-1:0] first_longitude_i;
  logic signed [LAT_W-1:0] second_latitude_i;
  logic signed [LON_W-1:0] second_longitude_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [DIST_W-1:0]       distance_km_o;

  int fail_count;
  int pending;
  int checked;
  int sent;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  great_circle_distance dut (.*);

  gcd_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o),
    .first_latitude_i, .first_longitude_i, .second_latitude_i, .second_longitude_i,
    .out_valid_i(out_valid_o), .out_ready_i, .distance_km_i(distance_km_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver back-pressure
  initial begin
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      out_ready_i = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("** great_circle_distance: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pair(input logic signed [LAT_W-1:0] lat1,
                           input logic signed [LON_W-1:0] lon1,
                           input logic signed [LAT_W-1:0] lat2,
                           input logic signed [LON_W-1:0] lon2);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    first_latitude_i = lat1;
    first_longitude_i = lon1;
    second_latitude_i = lat2;
    second_longitude_i = lon2;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  function automatic logic signed [LAT_W-1:0] any_lat();
    if ($urandom_range(9) == 0) return LAT_W'($urandom);
    return LAT_W'($urandom_range(2 * LAT_MAX) - LAT_MAX);
  endfunction

  function automatic logic signed [LON_W-1:0] any_lon();
    if ($urandom_range(9) == 0) return LON_W'($urandom);
    return LON_W'($urandom_range(2 * LON_MAX) - LON_MAX);
  endfunction

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    first_latitude_i = '0;
    first_longitude_i = '0;
    second_latitude_i = '0;
    second_longitude_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sent = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // corners: same point, poles, antipodes, date line, raw extremes
    send_pair(0, 0, 0, 0);
    send_pair(LAT_MAX, 0, -LAT_MAX, 0);
    send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    send_pair(0, 0, 0, LON_MAX);
    send_pair(0, LON_MAX, 0, -LON_MAX);
    send_pair(0, -LON_MAX, 0, LON_MAX);
    send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
    send_pair(1, 1, 0, 0);
    send_pair(-1, -1, 0, 0);
    send_pair(1000, 2000, 1000, 2000);
    send_pair(3276800, 884736, -3276800, -10911744);
    send_pair({1'b0, {(LAT_W-1){1'b1}}}, {1'b0, {(LON_W-1){1'b1}}},
              {1'b1, {(LAT_W-1){1'b0}}}, {1'b1, {(LON_W-1){1'b0}}});
    send_pair({1'b1, {(LAT_W-1){1'b0}}}, {1'b1, {(LON_W-1){1'b0}}},
              {1'b0, {(LAT_W-1){1'b1}}}, {1'b0, {(LON_W-1){1'b1}}});
    send_pair('1, '1, '1, '1);
    send_pair(3276800, 0, 3276800, 1);
    send_pair(0, 0, 0, 11796479);

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      case (i * 4 / RANDOM_PAIRS)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      if (i == RANDOM_PAIRS / 2) begin
        // hold off until the pipeline has drained
        @(negedge clk_i);
        in_valid_i = 1'b0;
        wait (pending == 0);
      end
      if ($urandom_range(7) == 0) begin
        // nearby points, small distances
        logic signed [LAT_W-1:0] la;
        logic signed [LON_W-1:0] lo;
        la = any_lat();
        lo = any_lon();
        send_pair(la, lo, la + LAT_W'($urandom_range(2000) - 1000),
                  lo + LON_W'($urandom_range(2000) - 1000));
      end else begin
        send_pair(any_lat(), any_lon(), any_lat(), any_lon());
      end
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
    recv_stall_pct = 0;
    wait (pending == 0);
    repeat (1000) @(posedge clk_i);
    $display("sent %0d point pairs, checked %0d distances", sent, checked);
    $display("phases: free flow, idle sender, stalling receiver, both, one drain");
    if (fail_count == 0 && pending == 0) begin
      $display("** great_circle_distance: PASSED **");
    end else begin
      $display("** great_circle_distance: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
